// File: design/assert_macros.svh
// assertion macros shared by the touch key detector modules
// needs clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CTKD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define CTKD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: design/ctkd_pkg.sv
// types, constants and codes of the touch key detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ctkd_pkg;

  localparam int DATA_W      = 16;
  localparam int SUM_W       = 20;
  localparam int GRP_W       = 3;
  localparam int HOLD_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CAL_SAMPLES = 10;
  localparam int CAL_CNT_W   = 4;
  localparam int CAL_LAST    = CAL_SAMPLES - 1;
  localparam int MID_DIV     = CAL_SAMPLES - 4;
  localparam int DIV_SHIFT   = 24;
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + MID_DIV - 1) / MID_DIV;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int EV_DEPTH    = 4;
  localparam int EV_PTR_W    = 2;
  localparam int EV_CNT_W    = 3;

  localparam logic [DATA_W-1:0] FAIL_LIMIT  = 16'd32767;
  localparam logic [DATA_W-1:0] LOW_INIT    = 16'hFFFF;
  localparam logic [DATA_W-1:0] MARGIN_RST  = 16'd100;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST = 3'd3;
  localparam logic [GRP_W-1:0]  NORMAL_RST  = 3'd3;
  localparam logic [GRP_W-1:0]  REPEAT_RST  = 3'd6;

  localparam logic OP_CAL    = 1'b0;
  localparam logic OP_SCAN   = 1'b1;
  localparam logic KIND_CAL  = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_MARGIN   = 2'd0,
    REG_HOLDOFF_SCANS = 2'd1,
    REG_NORMAL_SIZE   = 2'd2,
    REG_REPEAT_SIZE   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] charge_time;
    logic              repeat_mode;
  } ctkd_in_t;

  typedef struct packed {
    logic              kind;
    logic              pressed;
    logic [DATA_W-1:0] baseline_out;
    logic              cal_fail;
  } ctkd_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] gate_margin;
    logic [HOLD_W-1:0] holdoff_scans;
    logic [GRP_W-1:0]  normal_group_size;
    logic [GRP_W-1:0]  repeat_group_size;
  } ctkd_cfg_t;

  // one finished batch or group on its way to the back end
  typedef struct packed {
    logic              kind;
    logic [SUM_W-1:0]  cal_sum;
    logic [DATA_W-1:0] low0;
    logic [DATA_W-1:0] low1;
    logic [DATA_W-1:0] high0;
    logic [DATA_W-1:0] high1;
    logic [DATA_W-1:0] grp_max;
    logic              grp_repeat;
  } ctkd_ev_t;

endpackage
`default_nettype wire

// File: design/capacitive_touch_key_detector.sv
// Capacitive touch key detector, top level.
// Channels: samples enter on in_valid_i / in_ready_i with payload in_i
// (op, charge_time, repeat_mode); results leave on out_valid_o / out_ready_i
// with payload out_o (kind, pressed, baseline_out, cal_fail). A transaction
// is one item. Configuration is a plain write port: cfg_we_i, cfg_idx_i,
// cfg_data_i, taken on any edge with cfg_we_i high, no read-back.
// Throughput: one sample per cycle while the event queue is not full. The
// front end updates running sums, extremes and group maxima in the accepting
// cycle and hands each finished batch or group to a four-entry event queue.
// Path: a scan result goes from the event queue to the output register; a
// calibration result, pushed with its tenth sample, goes through the back-end
// steps subtract, reciprocal multiply and finish, each of them registered.
// Only one result per batch or group is produced; partial ones produce none.
// Reset: baseline 0, hold-off clear, accumulators empty, config registers at
// margin 100, hold-off 3, group sizes 3 and 6.
// Stall: the output register holds its result until taken; the queue absorbs
// up to four events, after which in_ready_o falls until space frees up.
// depends on ctkd_pkg, ctkd_front, ctkd_evq, ctkd_back
`timescale 1ns / 1ps
`default_nettype none
module capacitive_touch_key_detector import ctkd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ctkd_in_t             in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ctkd_out_t                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i
);

  ctkd_cfg_t cfg_q, cfg_d;
  logic      accept;
  logic      push, pop, full, ev_valid;
  ctkd_ev_t  ev_push, ev_head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GATE_MARGIN:   cfg_d.gate_margin       = cfg_data_i;
        REG_HOLDOFF_SCANS: cfg_d.holdoff_scans     = cfg_data_i[HOLD_W-1:0];
        REG_NORMAL_SIZE:   cfg_d.normal_group_size = cfg_data_i[GRP_W-1:0];
        REG_REPEAT_SIZE:   cfg_d.repeat_group_size = cfg_data_i[GRP_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_margin       <= MARGIN_RST;
      cfg_q.holdoff_scans     <= HOLDOFF_RST;
      cfg_q.normal_group_size <= NORMAL_RST;
      cfg_q.repeat_group_size <= REPEAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ctkd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .ev_o     (ev_push)
  );

  ctkd_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ev_i    (ev_push),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (ev_valid),
    .ev_o    (ev_head)
  );

  ctkd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ev_valid_i  (ev_valid),
    .ev_i        (ev_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

// File: design/ctkd_front.sv
// front end: accepts samples, keeps calibration and scan accumulators
// emits one event per finished batch or group; uses ctkd_pkg
`timescale 1ns / 1ps
`default_nettype none
module ctkd_front import ctkd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire ctkd_in_t  in_i,
  input  wire ctkd_cfg_t cfg_i,
  output logic           push_o,
  output ctkd_ev_t       ev_o
);

  logic [CAL_CNT_W-1:0] cal_count_q, cal_count_d;
  logic [SUM_W-1:0]     cal_sum_q, cal_sum_d;
  logic [DATA_W-1:0]    low0_q, low0_d, low1_q, low1_d;
  logic [DATA_W-1:0]    high0_q, high0_d, high1_q, high1_d;
  logic [GRP_W-1:0]     scan_count_q, scan_count_d;
  logic [DATA_W-1:0]    scan_max_q, scan_max_d;
  logic                 grp_repeat_q, grp_repeat_d;

  always_comb begin
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] nl0, nl1, nh0, nh1, mx0, mx;
    logic [SUM_W-1:0]  sum_n;
    logic              rep;
    logic [GRP_W-1:0]  size;
    v            = in_i.charge_time;
    cal_count_d  = cal_count_q;
    cal_sum_d    = cal_sum_q;
    low0_d       = low0_q;
    low1_d       = low1_q;
    high0_d      = high0_q;
    high1_d      = high1_q;
    scan_count_d = scan_count_q;
    scan_max_d   = scan_max_q;
    grp_repeat_d = grp_repeat_q;
    push_o       = 1'b0;
    ev_o         = '0;

    nl0 = low0_q;
    nl1 = low1_q;
    if (v < low0_q) begin
      nl1 = low0_q;
      nl0 = v;
    end else if (v < low1_q) begin
      nl1 = v;
    end
    nh0 = high0_q;
    nh1 = high1_q;
    if (v > high0_q) begin
      nh1 = high0_q;
      nh0 = v;
    end else if (v > high1_q) begin
      nh1 = v;
    end
    sum_n = cal_sum_q + SUM_W'(v);

    rep  = (scan_count_q == '0) ? in_i.repeat_mode : grp_repeat_q;
    mx0  = (scan_count_q == '0) ? '0 : scan_max_q;
    mx   = (v > mx0) ? v : mx0;
    size = rep ? cfg_i.repeat_group_size : cfg_i.normal_group_size;
    if (size == '0) begin
      size = GRP_W'(1);
    end

    ev_o.cal_sum    = sum_n;
    ev_o.low0       = nl0;
    ev_o.low1       = nl1;
    ev_o.high0      = nh0;
    ev_o.high1      = nh1;
    ev_o.grp_max    = mx;
    ev_o.grp_repeat = rep;

    if (accept_i) begin
      if (in_i.op == OP_CAL) begin
        ev_o.kind = KIND_CAL;
        if (cal_count_q >= CAL_CNT_W'(CAL_LAST)) begin
          push_o      = 1'b1;
          cal_count_d = '0;
          cal_sum_d   = '0;
          low0_d      = LOW_INIT;
          low1_d      = LOW_INIT;
          high0_d     = '0;
          high1_d     = '0;
        end else begin
          cal_count_d = cal_count_q + CAL_CNT_W'(1);
          cal_sum_d   = sum_n;
          low0_d      = nl0;
          low1_d      = nl1;
          high0_d     = nh0;
          high1_d     = nh1;
        end
      end else begin
        ev_o.kind    = KIND_SCAN;
        scan_max_d   = mx;
        grp_repeat_d = rep;
        if ({1'b0, scan_count_q} + 4'd1 < {1'b0, size}) begin
          scan_count_d = scan_count_q + GRP_W'(1);
        end else begin
          scan_count_d = '0;
          push_o       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_count_q  <= '0;
      cal_sum_q    <= '0;
      low0_q       <= LOW_INIT;
      low1_q       <= LOW_INIT;
      high0_q      <= '0;
      high1_q      <= '0;
      scan_count_q <= '0;
      scan_max_q   <= '0;
      grp_repeat_q <= 1'b0;
    end else begin
      cal_count_q  <= cal_count_d;
      cal_sum_q    <= cal_sum_d;
      low0_q       <= low0_d;
      low1_q       <= low1_d;
      high0_q      <= high0_d;
      high1_q      <= high1_d;
      scan_count_q <= scan_count_d;
      scan_max_q   <= scan_max_d;
      grp_repeat_q <= grp_repeat_d;
    end
  end

endmodule
`default_nettype wire

// File: design/ctkd_evq.sv
// event queue between front and back end
// uses ctkd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctkd_evq import ctkd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire ctkd_ev_t ev_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          valid_o,
  output ctkd_ev_t      ev_o
);

  ctkd_ev_t             slot_q [EV_DEPTH];
  logic [EV_PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [EV_CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == EV_CNT_W'(EV_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign ev_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + EV_PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + EV_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + EV_CNT_W'(push_i) - EV_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `CTKD_NEVER(a_no_push_full, push_i && full_o, "event pushed into full queue")
  `CTKD_NEVER(a_no_pop_empty, pop_i && !valid_o, "event popped from empty queue")
  `CTKD_ASSERT(a_cnt_range, cnt_q <= EV_CNT_W'(EV_DEPTH), "queue fill count out of range")

endmodule
`default_nettype wire

// File: design/ctkd_back.sv
// back end: baseline division, touch decision, hold-off and output register
// uses ctkd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ctkd_back import ctkd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctkd_cfg_t cfg_i,
  input  wire logic      ev_valid_i,
  input  wire ctkd_ev_t  ev_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ctkd_out_t      out_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_FIN  = 3'b100
  } back_state_e;

  back_state_e       state_q, state_d;
  logic [SUM_W-1:0]  mid_q, mid_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] baseline_q, baseline_d;
  logic [HOLD_W-1:0] holdoff_q, holdoff_d;
  logic              out_valid_q, out_valid_d;
  ctkd_out_t         out_q, out_d;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    logic              slot_free;
    logic [DATA_W-1:0] quot;
    logic [DATA_W:0]   upper;
    logic [SUM_W-1:0]  tenfold;
    logic              touch;
    logic [HOLD_W-1:0] h;
    slot_free   = !out_valid_q || out_ready_i;
    state_d     = state_q;
    mid_d       = mid_q;
    prod_d      = prod_q;
    baseline_d  = baseline_q;
    holdoff_d   = holdoff_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    quot        = prod_q[DIV_SHIFT +: DATA_W];
    upper       = {1'b0, baseline_q} + {1'b0, cfg_i.gate_margin};
    tenfold     = (SUM_W'(baseline_q) << 3) + (SUM_W'(baseline_q) << 1);
    touch       = ({1'b0, ev_i.grp_max} > upper) && (SUM_W'(ev_i.grp_max) < tenfold);
    h           = ev_i.grp_repeat ? '0 : holdoff_q;

    unique case (state_q)
      B_IDLE: begin
        if (ev_valid_i) begin
          if (ev_i.kind == KIND_CAL) begin
            pop_o   = 1'b1;
            mid_d   = ev_i.cal_sum - SUM_W'(ev_i.low0) - SUM_W'(ev_i.low1)
                      - SUM_W'(ev_i.high0) - SUM_W'(ev_i.high1);
            state_d = B_MUL;
          end else if (slot_free) begin
            pop_o = 1'b1;
            out_d.kind         = KIND_SCAN;
            out_d.pressed      = touch && (h == '0);
            out_d.baseline_out = baseline_q;
            out_d.cal_fail     = 1'b0;
            out_valid_d        = 1'b1;
            if (touch) begin
              h = cfg_i.holdoff_scans;
            end
            holdoff_d = (h != '0) ? h - HOLD_W'(1) : h;
          end
        end
      end
      B_MUL: begin
        prod_d  = {{RECIP_W{1'b0}}, mid_q} * {{SUM_W{1'b0}}, RECIP_W'(DIV_RECIP)};
        state_d = B_FIN;
      end
      B_FIN: begin
        if (slot_free) begin
          baseline_d         = quot;
          out_d.kind         = KIND_CAL;
          out_d.pressed      = 1'b0;
          out_d.baseline_out = quot;
          out_d.cal_fail     = (quot > FAIL_LIMIT);
          out_valid_d        = 1'b1;
          state_d            = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mid_q  <= mid_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      baseline_q  <= '0;
      holdoff_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      baseline_q  <= baseline_d;
      holdoff_q   <= holdoff_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CTKD_ASSERT(a_mul_to_fin, (state_q == B_MUL) |=> (state_q == B_FIN), "multiply step not followed by finish")
  `CTKD_NEVER(a_pop_busy, pop_o && (state_q != B_IDLE), "event taken while division in flight")

endmodule
`default_nettype wire

// File: test/tb_top.sv
// self-checking testbench of the capacitive touch key detector
// depends on ctkd_pkg and capacitive_touch_key_detector
`timescale 1ns / 1ps
module tb_top;
  import ctkd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int PRESSURE_PHASE  = 5;
  localparam int N_DIRECTED      = 26;

  typedef struct packed {
    ctkd_in_t  sample;
    logic      typed;
    ctkd_out_t result;
  } dir_row_t;

  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{'{OP_SCAN, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_SCAN, 16'h0000, 1'b1}, 1'b0, '0},
    '{'{OP_SCAN, 16'h8000, 1'b0}, 1'b1, '{KIND_SCAN, 1'b0, 16'h0000, 1'b0}},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b1}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b1, '{KIND_CAL, 1'b0, 16'hFFFF, 1'b1}},
    '{'{OP_CAL, 16'h0000, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFF, 1'b0}, 1'b0, '0},
    '{'{OP_SCAN, 16'h01F4, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h0001, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'hFFFE, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h012C, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h0136, 1'b0}, 1'b0, '0},
    '{'{OP_SCAN, 16'h0A00, 1'b1}, 1'b0, '0},
    '{'{OP_CAL, 16'h0140, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h014A, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h0154, 1'b0}, 1'b0, '0},
    '{'{OP_CAL, 16'h015E, 1'b0}, 1'b0, '0},
    '{'{OP_SCAN, 16'h03E8, 1'b0}, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ctkd_in_t             in_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ctkd_out_t            out_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  // predictor copy of the settings and of the detector state
  int unsigned margin_set, holdoff_set, normal_size_set, repeat_size_set;
  int unsigned batch_count, batch_sum, batch_low [2], batch_high [2], baseline_now;
  int unsigned group_count, group_peak, holdoff_left;
  bit          group_rep;

  ctkd_out_t   awaited_results [$];
  ctkd_out_t   head_result;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_on = 1'b0;

  capacitive_touch_key_detector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_batch();
    batch_count   = 0;
    batch_sum     = 0;
    batch_low[0]  = LOW_INIT;
    batch_low[1]  = LOW_INIT;
    batch_high[0] = 0;
    batch_high[1] = 0;
  endfunction

  // works out the result, if any, that one accepted sample causes
  task automatic predict_touch(input ctkd_in_t s, output bit has_result, output ctkd_out_t r);
    int unsigned v, mid, size;
    bit          press;
    v = s.charge_time;
    has_result = 1'b0;
    r = '0;
    if (s.op == OP_CAL) begin
      if (v < batch_low[0]) begin
        batch_low[1] = batch_low[0];
        batch_low[0] = v;
      end else if (v < batch_low[1]) begin
        batch_low[1] = v;
      end
      if (v > batch_high[0]) begin
        batch_high[1] = batch_high[0];
        batch_high[0] = v;
      end else if (v > batch_high[1]) begin
        batch_high[1] = v;
      end
      batch_sum = (batch_sum + v) & ((1 << SUM_W) - 1);
      if (batch_count + 1 >= CAL_SAMPLES) begin
        mid = batch_sum - batch_low[0] - batch_low[1] - batch_high[0] - batch_high[1];
        baseline_now = (mid / (CAL_SAMPLES - 4)) & 16'hFFFF;
        clear_batch();
        has_result = 1'b1;
        r.kind = KIND_CAL;
        r.baseline_out = baseline_now[DATA_W-1:0];
        r.cal_fail = (baseline_now > FAIL_LIMIT);
      end else begin
        batch_count++;
      end
    end else begin
      if (group_count == 0) begin
        group_rep = s.repeat_mode;
        group_peak = 0;
      end
      if (v > group_peak) begin
        group_peak = v;
      end
      size = group_rep ? repeat_size_set : normal_size_set;
      if (size == 0) begin
        size = 1;
      end
      if (group_count + 1 < size) begin
        group_count++;
      end else begin
        group_count = 0;
        press = 1'b0;
        if (group_rep) begin
          holdoff_left = 0;
        end
        if (group_peak > baseline_now + margin_set && group_peak < 10 * baseline_now) begin
          press = (holdoff_left == 0);
          holdoff_left = holdoff_set;
        end
        if (holdoff_left != 0) begin
          holdoff_left--;
        end
        has_result = 1'b1;
        r.kind = KIND_SCAN;
        r.pressed = press;
        r.baseline_out = baseline_now[DATA_W-1:0];
      end
    end
  endtask

  task automatic offer_sample(input ctkd_in_t s, input bit typed, input ctkd_out_t typed_result);
    bit        has_result;
    ctkd_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predict_touch(s, has_result, r);
    if (has_result) begin
      awaited_results.push_back(typed ? typed_result : r);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      REG_GATE_MARGIN:   margin_set = val & 16'hFFFF;
      REG_HOLDOFF_SCANS: holdoff_set = val & 3'h7;
      REG_NORMAL_SIZE:   normal_size_set = val & 3'h7;
      REG_REPEAT_SIZE:   repeat_size_set = val & 3'h7;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int unsigned margin, hold, nsize, rsize);
    write_reg(REG_GATE_MARGIN, margin);
    write_reg(REG_HOLDOFF_SCANS, hold);
    write_reg(REG_NORMAL_SIZE, nsize);
    write_reg(REG_REPEAT_SIZE, rsize);
    cfg_we_i <= 1'b0;
  endtask

  // mostly samples near the pad level or clear touches, some pure noise
  function automatic ctkd_in_t make_sample(input int unsigned level, input int unsigned margin);
    ctkd_in_t    s;
    int unsigned pick, v;
    s.op = ($urandom_range(99) < 25) ? OP_CAL : OP_SCAN;
    s.repeat_mode = ($urandom_range(99) < 30);
    pick = $urandom_range(99);
    if (pick < 10) begin
      v = $urandom_range(0, 65535);
    end else if (s.op == OP_CAL || pick < 55) begin
      v = ((level > 20) ? level - 20 : 0) + $urandom_range(0, 40);
    end else begin
      v = level + margin + 1 + $urandom_range(0, level * 8);
    end
    s.charge_time = (v > 65535) ? 16'hFFFF : v[DATA_W-1:0];
    return s;
  endfunction

  task automatic wait_idle();
    while (awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // receiver side, with one long hold-off at least in the pressure phase
  initial begin
    int unsigned hold_left;
    bit          pressure_done;
    hold_left = 0;
    pressure_done = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_on && !pressure_done) begin
        hold_left = 100;
        pressure_done = 1'b1;
      end else if (pressure_on && hold_left == 0 && $urandom_range(99) < 3) begin
        hold_left = $urandom_range(40, 100);
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        if (error_count < 30) begin
          $display("%0t: unexpected result kind %0d pressed %0d baseline %0d cal_fail %0d",
                   $time, out_o.kind, out_o.pressed, out_o.baseline_out, out_o.cal_fail);
        end
        error_count++;
      end else begin
        head_result = awaited_results.pop_front();
        if (out_o.kind !== head_result.kind || out_o.pressed !== head_result.pressed ||
            out_o.baseline_out !== head_result.baseline_out ||
            out_o.cal_fail !== head_result.cal_fail) begin
          if (error_count < 30) begin
            $display("%0t: mismatch expected kind %0d pressed %0d baseline %0d cal_fail %0d",
                     $time, head_result.kind, head_result.pressed,
                     head_result.baseline_out, head_result.cal_fail);
            $display("%0t:          actual kind %0d pressed %0d baseline %0d cal_fail %0d",
                     $time, out_o.kind, out_o.pressed, out_o.baseline_out, out_o.cal_fail);
          end
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[capacitive_touch_key_detector] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned level;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_GATE_MARGIN;
    cfg_data_i = '0;
    margin_set = MARGIN_RST;
    holdoff_set = HOLDOFF_RST;
    normal_size_set = NORMAL_RST;
    repeat_size_set = REPEAT_RST;
    clear_batch();
    baseline_now = 0;
    group_count = 0;
    group_peak = 0;
    group_rep = 1'b0;
    holdoff_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_sample(DIRECTED[i].sample, DIRECTED[i].typed, DIRECTED[i].result);
    end
    in_valid_i <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: load_settings(0, 0, 1, 1);
        1: load_settings(16'hFFFF, 7, 7, 7);
        2: load_settings(MARGIN_RST, HOLDOFF_RST, NORMAL_RST, REPEAT_RST);
        default: load_settings(($urandom_range(3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 400),
                               $urandom_range(0, 7),
                               (phase == 3) ? 0 : $urandom_range(0, 7),
                               (phase == 4) ? 0 : $urandom_range(0, 7));
      endcase
      pressure_on = (phase == PRESSURE_PHASE);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (pressure_on) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      level = ($urandom_range(4) == 0) ? $urandom_range(0, 65535) : $urandom_range(20, 3000);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        offer_sample(make_sample(level, margin_set), 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end
    pressure_on = 1'b0;

    wait_idle();
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("[capacitive_touch_key_detector] OK");
    end else begin
      $display("[capacitive_touch_key_detector] ERROR");
    end
    $finish;
  end

endmodule
